FILE: rtl/core/ibbl_pkg.sv
// ----------------------------------------------------------------------------
// ibbl_pkg
// shared defaults, field widths and register indexes of the blur / laplacian unit
// ----------------------------------------------------------------------------
package ibbl_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int MAX_WINDOW_DEF = 7;

    localparam int PIX_W    = 8;
    localparam int FW_REG_W = 11;
    localparam int FH_REG_W = 13;
    localparam int WS_REG_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE  = 2'd0,
        REG_WINDOW_SIZE  = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        WT_ZERO = 2'd0,
        WT_ONE  = 2'd1,
        WT_NEG4 = 2'd2
    } t_weight;

endpackage

FILE: rtl/core/image_box_blur_laplacian_filter_unit.sv
// ----------------------------------------------------------------------------
// image_box_blur_laplacian_filter_unit
// streaming box blur / 4-neighbour laplacian with replicated borders
// ----------------------------------------------------------------------------
// sequence: an accepted item goes to S_CHECK and, if it releases no result,
//   back to S_IDLE; otherwise it runs S_TAPS, S_TAIL, S_PREP, S_DIV (box blur
//   mode only) and S_EMIT before it frees the input
// throughput: one item at a time; every window tap is one read of the single
//   line store read port, which sets the rate, and any stall on the result
//   channel holds the item in S_EMIT
// reset: synchronous active low; clears counters, peak, fsm, output valid and
//   configuration registers to their defaults; the line store is not cleared and needs no clearing pass
module image_box_blur_laplacian_filter_unit
    import ibbl_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [PIX_W-1:0]      i_pixel_in,
    // result item channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_frame_end,
    output logic [PIX_W-1:0]      o_peak_value,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // largest odd window inside MAX_WINDOW
    localparam int KMAX   = (MAX_WINDOW - 1) | 1;
    localparam int K_W    = ($clog2(KMAX + 1) > 3) ? $clog2(KMAX + 1) : 3;
    localparam int KK_W   = 2 * K_W;
    localparam int HS_W   = $clog2(KMAX / 2 + 1);
    localparam int IDX_W  = $clog2(KMAX);
    // store rows rounded up to a power of two so the row slot is a bit-select
    localparam int SLOT_W = $clog2(MAX_WINDOW + 1);
    localparam int ROWS   = 1 << SLOT_W;
    localparam int DEPTH  = ROWS * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int RS_W   = ROW_W + 2;
    localparam int CS_W   = W_W + 2;
    localparam int SUM_W  = $clog2(KMAX * KMAX * 255 + 1) + 2;
    localparam int DV_W   = SUM_W + PIX_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_TAPS, S_TAIL, S_PREP, S_DIV, S_EMIT
    } t_state;

    // configuration registers
    logic                r_filter_mode;
    logic [WS_REG_W-1:0] r_window_size;
    logic [FW_REG_W-1:0] r_frame_width;
    logic [FH_REG_W-1:0] r_frame_height;

    // frame counters
    logic [COL_W-1:0]    r_in_col;
    logic [ROW_W-1:0]    r_in_row;
    logic [COL_W-1:0]    r_out_col;
    logic [ROW_W-1:0]    r_out_row;
    logic [PIX_W-1:0]    r_peak;

    t_state              r_state;
    logic [IDX_W-1:0]    r_ti;
    logic [IDX_W-1:0]    r_tj;
    logic                r_tap_pend;
    t_weight             r_tap_wt;
    logic signed [SUM_W-1:0] r_acc;
    logic [DV_W-1:0]     r_rem;
    logic [PIX_W-1:0]    r_quo;
    logic [2:0]          r_dbit;
    logic [PIX_W-1:0]    r_value;

    logic                r_o_valid;
    logic [PIX_W-1:0]    r_o_pixel;
    logic                r_o_end;
    logic [PIX_W-1:0]    r_o_peak;

    // effective geometry
    logic [W_W-1:0]      eff_w;
    logic [ROW_W-1:0]    eff_h;
    logic [K_W-1:0]      k_odd;
    logic [K_W-1:0]      box_k;
    logic [KK_W-1:0]     box_kk;
    logic [HS_W-1:0]     hs;
    logic [IDX_W-1:0]    span;

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = W_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = W_W'(MAX_WIDTH);
        end else begin
            eff_w = W_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = ROW_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_h = ROW_W'(r_frame_height);
        end
        k_odd = K_W'(r_window_size | WS_REG_W'(1));
        if (k_odd < K_W'(3)) begin
            box_k = K_W'(3);
        end else if (k_odd > K_W'(KMAX)) begin
            box_k = K_W'(KMAX);
        end else begin
            box_k = k_odd;
        end
        box_kk = KK_W'(box_k) * KK_W'(box_k);
        hs     = r_filter_mode ? HS_W'(1) : HS_W'(box_k >> 1);
        span   = IDX_W'({hs, 1'b0});
    end

    // input side: push into the line store
    logic              in_acc;
    logic              push;
    logic              we;
    logic [ADDR_W-1:0] waddr;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign push    = in_acc && !i_action && (r_in_row < eff_h);
    assign we      = push;
    assign waddr   = ADDR_W'(r_in_row[SLOT_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_in_col);

    // readiness of the next result
    logic [ROW_W:0] need_r;
    logic [W_W:0]   need_c;
    logic           res_ready;

    always_comb begin
        need_r = (ROW_W+1)'(r_out_row) + (ROW_W+1)'(hs);
        if (need_r > (ROW_W+1)'(eff_h) - (ROW_W+1)'(1)) begin
            need_r = (ROW_W+1)'(eff_h) - (ROW_W+1)'(1);
        end
        need_c = (W_W+1)'(r_out_col) + (W_W+1)'(hs);
        if (need_c > (W_W+1)'(eff_w) - (W_W+1)'(1)) begin
            need_c = (W_W+1)'(eff_w) - (W_W+1)'(1);
        end
        res_ready = (r_in_row >= eff_h) || ((ROW_W+1)'(r_in_row) > need_r)
                 || (((ROW_W+1)'(r_in_row) == need_r) && ((W_W+1)'(r_in_col) > need_c));
    end

    // tap address: clamp the window position to the frame
    logic [RS_W-1:0]   tap_ur;
    logic [CS_W-1:0]   tap_uc;
    logic [ROW_W-1:0]  tap_row;
    logic [COL_W-1:0]  tap_col;
    logic [ADDR_W-1:0] raddr;
    t_weight           tap_wt;

    always_comb begin
        tap_ur = RS_W'(r_out_row) + RS_W'(r_ti) - RS_W'(hs);
        tap_uc = CS_W'(r_out_col) + CS_W'(r_tj) - CS_W'(hs);
        if ($signed(tap_ur) < 0) begin
            tap_row = '0;
        end else if (tap_ur > RS_W'(eff_h) - RS_W'(1)) begin
            tap_row = eff_h - ROW_W'(1);
        end else begin
            tap_row = ROW_W'(tap_ur);
        end
        if ($signed(tap_uc) < 0) begin
            tap_col = '0;
        end else if (tap_uc > CS_W'(eff_w) - CS_W'(1)) begin
            tap_col = COL_W'(eff_w - W_W'(1));
        end else begin
            tap_col = COL_W'(tap_uc);
        end
        raddr = ADDR_W'(tap_row[SLOT_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tap_col);
        // laplacian: centre -4, edge neighbours +1, corners unused
        if (!r_filter_mode) begin
            tap_wt = WT_ONE;
        end else if ((r_ti == IDX_W'(1)) && (r_tj == IDX_W'(1))) begin
            tap_wt = WT_NEG4;
        end else if ((r_ti == IDX_W'(1)) != (r_tj == IDX_W'(1))) begin
            tap_wt = WT_ONE;
        end else begin
            tap_wt = WT_ZERO;
        end
    end

    logic [PIX_W-1:0] rdata;

    ibbl_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_pixel_in),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // divider step and result bookkeeping
    logic [DV_W-1:0]  div_sub;
    logic             div_fit;
    logic             out_last_col;
    logic             out_last;
    logic [PIX_W-1:0] new_peak;
    logic             in_wrap;
    logic             emit_go;

    always_comb begin
        div_sub      = DV_W'(box_kk) << r_dbit;
        div_fit      = (r_rem >= div_sub);
        out_last_col = ((W_W+1)'(r_out_col) + (W_W+1)'(1)) >= (W_W+1)'(eff_w);
        out_last     = out_last_col
                    && (((ROW_W+1)'(r_out_row) + (ROW_W+1)'(1)) >= (ROW_W+1)'(eff_h));
        new_peak     = (r_value > r_peak) ? r_value : r_peak;
        in_wrap      = ((W_W+1)'(r_in_col) + (W_W+1)'(1)) >= (W_W+1)'(eff_w);
        // result moves into the output register once that register is free
        emit_go      = (r_state == S_EMIT) && (!r_o_valid || i_ready);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= 1'b0;
            r_window_size  <= WS_REG_W'(3);
            r_frame_width  <= FW_REG_W'(1024);
            r_frame_height <= FH_REG_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FILTER_MODE:  r_filter_mode  <= i_cfg_data[0];
                REG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[WS_REG_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_REG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // accumulate tap data in the cycle after its read was issued
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_acc <= '0;
        end else if (r_tap_pend) begin
            case (r_tap_wt)
                WT_ONE:  r_acc <= r_acc + SUM_W'(rdata);
                WT_NEG4: r_acc <= r_acc - SUM_W'({rdata, 2'b00});
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_peak     <= '0;
            r_tap_pend <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            // a tap read issued now returns its data next cycle
            r_tap_pend <= (r_state == S_TAPS);
            if (emit_go) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (push) begin
                            if (in_wrap) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + ROW_W'(1);
                            end else begin
                                r_in_col <= r_in_col + COL_W'(1);
                            end
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_ti <= '0;
                    r_tj <= '0;
                    r_state <= res_ready ? S_TAPS : S_IDLE;
                end
                S_TAPS: begin
                    r_tap_wt   <= tap_wt;
                    if (r_tj == span) begin
                        r_tj <= '0;
                        r_ti <= r_ti + IDX_W'(1);
                        if (r_ti == span) begin
                            r_state <= S_TAIL;
                        end
                    end else begin
                        r_tj <= r_tj + IDX_W'(1);
                    end
                end
                S_TAIL: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (r_filter_mode) begin
                        if (r_acc < 0) begin
                            r_value <= '0;
                        end else if (r_acc > SUM_W'(255)) begin
                            r_value <= PIX_W'(255);
                        end else begin
                            r_value <= PIX_W'(r_acc);
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_rem   <= DV_W'(r_acc);
                        r_quo   <= '0;
                        r_dbit  <= 3'd7;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_fit) begin
                        r_rem        <= r_rem - div_sub;
                        r_quo[r_dbit] <= 1'b1;
                    end
                    if (r_dbit == 3'd0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_dbit <= r_dbit - 3'd1;
                    end
                    if ((r_dbit == 3'd0)) begin
                        r_value <= div_fit ? (r_quo | PIX_W'(1)) : r_quo;
                    end
                end
                S_EMIT: begin
                    // wait while the previous result still sits in the output register
                    if (emit_go) begin
                        r_o_pixel <= r_value;
                        r_o_peak  <= new_peak;
                        r_o_end   <= out_last;
                        r_peak    <= out_last ? '0 : new_peak;
                        if (out_last_col) begin
                            r_out_col <= '0;
                            if (!out_last) begin
                                r_out_row <= r_out_row + ROW_W'(1);
                            end
                        end else begin
                            r_out_col <= r_out_col + COL_W'(1);
                        end
                        if (out_last) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_row <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_pixel_out  = r_o_pixel;
    assign o_frame_end  = r_o_end;
    assign o_peak_value = r_o_peak;

    a_peak_covers_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_value >= o_pixel_out))
        else $error("peak below its own pixel");

    a_accept_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CHECK))
        else $error("accepted item not checked");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && o_frame_end) |->
            (r_out_row == '0 && r_out_col == '0 && r_peak == '0 && r_in_row == '0))
        else $error("counters not cleared at frame end");

    a_emit_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !res_ready) |=> (r_state == S_IDLE && !$rose(o_valid)))
        else $error("result released too early");

endmodule

FILE: rtl/core/ibbl_ram.sv
// ----------------------------------------------------------------------------
// ibbl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ibbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
